FILE: hw/rtl/ldsp_pkg.sv
package ldsp_pkg;

  localparam int LED_COUNT     = 6;
  localparam int PATTERN_COUNT = 4;

  localparam int MASK_W  = 6;
  localparam int PORT_W  = 5;
  localparam int POS_W   = 5;
  localparam int SEL_W   = 2;
  localparam int SCAN_W  = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int TABLE_SLOTS = 21;

  localparam logic [PORT_W-1:0] DARK_CODE = 5'h10;

  typedef enum logic [2:0] {
    ACT_SCAN   = 3'd0,
    ACT_EFFECT = 3'd1,
    ACT_LOAD   = 3'd2,
    ACT_OFF    = 3'd3,
    ACT_START  = 3'd4
  } action_t;

  // entries already cut to the six mask bits (the first strip entry is dark)
  localparam logic [MASK_W-1:0] PATTERN_TABLE [0:3][0:TABLE_SLOTS-1] = '{
    '{6'd0, 6'd1, 6'd3, 6'd7, 6'd15, 6'd31, 6'd63, 6'd0, 6'd0, 6'd0, 6'd0,
      6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0},
    '{6'd33, 6'd18, 6'd12, 6'd12, 6'd18, 6'd33, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
      6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0},
    '{6'd32, 6'd16, 6'd8, 6'd4, 6'd2, 6'd1, 6'd33, 6'd17, 6'd9, 6'd5, 6'd3,
      6'd35, 6'd19, 6'd11, 6'd7, 6'd39, 6'd23, 6'd15, 6'd47, 6'd31, 6'd63},
    '{6'd1, 6'd2, 6'd4, 6'd8, 6'd16, 6'd32, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
      6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0}
  };

  localparam logic [POS_W-1:0] PATTERN_LENGTH [0:3] = '{5'd7, 5'd6, 5'd21, 5'd6};

  function automatic logic [MASK_W-1:0] pattern_entry(input logic [SEL_W-1:0] sel,
                                                      input logic [POS_W-1:0] pos);
    logic [MASK_W-1:0] e;
    e = '0;
    if (pos < POS_W'(TABLE_SLOTS)) begin
      e = PATTERN_TABLE[sel][pos];
    end
    return e;
  endfunction

  typedef struct packed {
    logic              drive_valid;
    logic [PORT_W-1:0] port_value;
    logic              effect_running;
    logic [MASK_W-1:0] led_mask;
  } result_t;

endpackage

FILE: hw/rtl/led_demux_scan_with_pattern_effects_core.sv
// LED demux scan with pattern effects.
//
// Input stream (s_axis_*): one command word per handshake. tuser carries the
// action code (scan tick, effect tick, load mask, all off, start effect),
// tdata carries the mask and the effect number.
// Output stream (m_axis_*): exactly one result word per command. tuser[0]
// says the word drove the demux (scan tick); tdata carries the demux code,
// the effect-running flag and the LED mask after the command.
//
// The state update and the result are computed from the accepted word and
// registered at the same edge. Throughput is one word per cycle while the
// skid is empty, set by the single registered update of the scan/walk state.
// A two-entry output stage (result register plus skid register) lets one more
// word in while the receiver stalls; s_axis_tready drops only when both are
// full, and nothing is lost or reordered.
// Reset (rst, synchronous) darkens all LEDs, rewinds the scan and the walk,
// clears the chosen table and the running flag, and empties the output stage.
module led_demux_scan_with_pattern_effects_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [5:0] mask, [8:6] effect_number, rest zero
  input  logic [2:0]  s_axis_tuser,   // [2:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [4:0] port_value, [5] effect_running,
                                      // [11:6] led_mask, rest zero
  output logic [0:0]  m_axis_tuser    // [0] drive_valid
);

  localparam int MW = ldsp_pkg::MASK_W;
  localparam int PW = ldsp_pkg::POS_W;
  localparam int SW = ldsp_pkg::SCAN_W;

  logic [MW-1:0]                on_mask, on_mask_next;
  logic [SW-1:0]                scan_position, scan_position_next;
  logic [PW-1:0]                pattern_position, pattern_position_next;
  logic                         walk_backward, walk_backward_next;
  logic                         pattern_chosen, pattern_chosen_next;
  logic [ldsp_pkg::SEL_W-1:0]   pattern_select, pattern_select_next;
  logic                         running_flag, running_flag_next;

  ldsp_pkg::result_t result, out_word, skid_word;
  logic              out_valid, skid_valid;
  logic              accept;

  ldsp_pkg::action_t action;
  logic [MW-1:0]     in_mask;
  logic [2:0]        in_effect;

  logic [MW-1:0]     scan_bits;
  logic              scan_lit;
  logic [SW:0]       scan_inc;
  logic [PW-1:0]     len, pos_cur;
  logic [PW:0]       pos_inc;
  logic              step_back;

  assign action    = ldsp_pkg::action_t'(s_axis_tuser);
  assign in_mask   = s_axis_tdata[5:0];
  assign in_effect = s_axis_tdata[8:6];

  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // scan code for the current position
  assign scan_bits = on_mask >> scan_position;
  assign scan_lit  = (32'(scan_position) < MW) && (32'(scan_position) < ldsp_pkg::LED_COUNT)
                     && scan_bits[0];
  assign scan_inc  = {1'b0, scan_position} + 1'b1;

  // walk helpers; position is kept below the table length, the clamp is a guard
  assign len       = ldsp_pkg::PATTERN_LENGTH[pattern_select];
  assign pos_cur   = (pattern_position >= len) ? '0 : pattern_position;
  assign pos_inc   = {1'b0, pos_cur} + 1'b1;
  assign step_back = walk_backward && (pos_cur != '0);

  always_comb begin
    on_mask_next          = on_mask;
    scan_position_next    = scan_position;
    pattern_position_next = pattern_position;
    walk_backward_next    = walk_backward;
    pattern_chosen_next   = pattern_chosen;
    pattern_select_next   = pattern_select;
    running_flag_next     = running_flag;
    result.drive_valid    = 1'b0;
    result.port_value     = '0;

    case (action)
      ldsp_pkg::ACT_SCAN: begin
        result.drive_valid = 1'b1;
        result.port_value  = scan_lit ? ldsp_pkg::PORT_W'(scan_position)
                                      : ldsp_pkg::DARK_CODE;
        if (32'(scan_inc) >= ldsp_pkg::LED_COUNT) begin
          scan_position_next = '0;
        end else begin
          scan_position_next = scan_inc[SW-1:0];
        end
      end
      ldsp_pkg::ACT_EFFECT: begin
        if (pattern_chosen) begin
          on_mask_next = ldsp_pkg::pattern_entry(pattern_select, pos_cur);
          if (step_back) begin
            walk_backward_next    = 1'b1;
            pattern_position_next = pos_cur - 1'b1;
          end else if (pos_inc >= {1'b0, len}) begin
            // far end shown once, turn back
            walk_backward_next    = 1'b1;
            pattern_position_next = (len >= PW'(2)) ? len - PW'(2) : '0;
          end else begin
            walk_backward_next    = 1'b0;
            pattern_position_next = pos_inc[PW-1:0];
          end
        end
      end
      ldsp_pkg::ACT_LOAD: begin
        on_mask_next = in_mask;
      end
      ldsp_pkg::ACT_OFF: begin
        on_mask_next      = '0;
        running_flag_next = 1'b0;
      end
      ldsp_pkg::ACT_START: begin
        if ((32'(in_effect) < ldsp_pkg::PATTERN_COUNT) && (in_effect < 3'd4)) begin
          pattern_select_next   = in_effect[ldsp_pkg::SEL_W-1:0];
          pattern_chosen_next   = 1'b1;
          running_flag_next     = 1'b1;
          pattern_position_next = '0;
          walk_backward_next    = 1'b0;
        end
      end
      default: begin
      end
    endcase

    result.effect_running = running_flag_next;
    result.led_mask       = on_mask_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      on_mask          <= '0;
      scan_position    <= '0;
      pattern_position <= '0;
      walk_backward    <= 1'b0;
      pattern_chosen   <= 1'b0;
      pattern_select   <= '0;
      running_flag     <= 1'b0;
    end else if (accept) begin
      on_mask          <= on_mask_next;
      scan_position    <= scan_position_next;
      pattern_position <= pattern_position_next;
      walk_backward    <= walk_backward_next;
      pattern_chosen   <= pattern_chosen_next;
      pattern_select   <= pattern_select_next;
      running_flag     <= running_flag_next;
    end
  end

  // output register with skid: skid fills only when the output word is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_axis_tready) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (accept) begin
        out_word <= result;
      end
    end else if (accept) begin
      skid_word <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_word.drive_valid;
  assign m_axis_tdata  = {4'b0000, out_word.led_mask, out_word.effect_running,
                          out_word.port_value};

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held with empty output register");

  a_port_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.drive_valid
                   ? (out_word.port_value == ldsp_pkg::DARK_CODE ||
                      32'(out_word.port_value) < ldsp_pkg::LED_COUNT)
                   : (out_word.port_value == '0)))
    else $error("bad demux code in result word");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    32'(scan_position) < ldsp_pkg::LED_COUNT)
    else $error("scan position past last LED");

  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    pattern_chosen |-> (pattern_position < len))
    else $error("pattern walk past end of table");

  a_running_needs_table: assert property (@(posedge clk) disable iff (rst)
    running_flag |-> pattern_chosen)
    else $error("effect running with no table chosen");
`endif

endmodule

FILE: tb/sv/led_demux_scan_with_pattern_effects_core_test.sv
module led_demux_scan_with_pattern_effects_core_test;

  localparam int RANDOM_ITEMS = 1550;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 80;

  // pattern tables as raw entries; only the low six bits reach the mask
  localparam logic [6:0] WALK_TABLE [0:3][0:ldsp_pkg::TABLE_SLOTS-1] = '{
    '{7'd64, 7'd1, 7'd3, 7'd7, 7'd15, 7'd31, 7'd63, 7'd0, 7'd0, 7'd0, 7'd0,
      7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0},
    '{7'd33, 7'd18, 7'd12, 7'd12, 7'd18, 7'd33, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
      7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0},
    '{7'd32, 7'd16, 7'd8, 7'd4, 7'd2, 7'd1, 7'd33, 7'd17, 7'd9, 7'd5, 7'd3,
      7'd35, 7'd19, 7'd11, 7'd7, 7'd39, 7'd23, 7'd15, 7'd47, 7'd31, 7'd63},
    '{7'd1, 7'd2, 7'd4, 7'd8, 7'd16, 7'd32, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
      7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0}
  };
  localparam int WALK_LEN [0:3] = '{7, 6, 21, 6};

  typedef struct packed {
    logic [2:0]                  action;
    logic [ldsp_pkg::MASK_W-1:0] mask;
    logic [2:0]                  effect;
  } cmd_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [5:0] mask, [8:6] effect_number, rest zero
  logic [2:0]  s_axis_tuser;   // [2:0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [4:0] port_value, [5] effect_running, [11:6] led_mask
  logic [0:0]  m_axis_tuser;   // [0] drive_valid

  led_demux_scan_with_pattern_effects_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  cmd_t              cmd_q[$];
  ldsp_pkg::result_t expected_q[$];
  int      total_cmds;
  int      sent_cnt;
  int      checked_cnt;
  int      drive_cnt;
  int      err_cnt;
  int      cycle_cnt;
  int      hold_left;
  bit      hold_done;

  // shadow of the block state
  logic [ldsp_pkg::MASK_W-1:0] led_on;
  int                          scan_pos;
  int                          walk_pos;
  bit                          walk_back;
  bit                          table_chosen;
  logic [ldsp_pkg::SEL_W-1:0]  table_sel;
  bit                          running;

  function automatic int phase_of(int n);
    if (n < total_cmds / 3) begin
      return 0;
    end else if (n < (2 * total_cmds) / 3) begin
      return 1;
    end
    return 2;
  endfunction

  function automatic int sender_idle_pct(int n);
    case (phase_of(n))
      0: begin
        return 11;
      end
      1: begin
        return 71;
      end
      default: begin
        return 0;
      end
    endcase
  endfunction

  function automatic int receiver_idle_pct(int n);
    case (phase_of(n))
      0: begin
        return 71;
      end
      1: begin
        return 11;
      end
      default: begin
        return 0;
      end
    endcase
  endfunction

  function automatic void walk_step();
    int len;
    if (!table_chosen) begin
      return;
    end
    len = WALK_LEN[table_sel];
    if (walk_pos >= len) begin
      walk_pos = 0;
    end
    led_on = WALK_TABLE[table_sel][walk_pos][ldsp_pkg::MASK_W-1:0];
    if (walk_pos == 0 && walk_back) begin
      walk_back = 1'b0;
    end
    if (walk_back) begin
      walk_pos--;
    end else begin
      walk_pos++;
      if (walk_pos >= len) begin
        walk_back = 1'b1;
        walk_pos  = (len >= 2) ? len - 2 : 0;
      end
    end
  endfunction

  function automatic ldsp_pkg::result_t demux_result(logic [2:0] act,
                                                     logic [ldsp_pkg::MASK_W-1:0] m,
                                                     logic [2:0] eff);
    ldsp_pkg::result_t r;
    r = '0;
    case (act)
      ldsp_pkg::ACT_SCAN: begin
        r.drive_valid = 1'b1;
        if (scan_pos < ldsp_pkg::LED_COUNT && scan_pos < 6 && led_on[scan_pos]) begin
          r.port_value = ldsp_pkg::PORT_W'(scan_pos);
        end else begin
          r.port_value = ldsp_pkg::DARK_CODE;
        end
        scan_pos++;
        if (scan_pos >= ldsp_pkg::LED_COUNT) begin
          scan_pos = 0;
        end
      end
      ldsp_pkg::ACT_EFFECT: begin
        walk_step();
      end
      ldsp_pkg::ACT_LOAD: begin
        led_on = m;
      end
      ldsp_pkg::ACT_OFF: begin
        led_on  = '0;
        running = 1'b0;
      end
      ldsp_pkg::ACT_START: begin
        if (int'(eff) < ldsp_pkg::PATTERN_COUNT && eff < 3'd4) begin
          table_sel    = eff[ldsp_pkg::SEL_W-1:0];
          table_chosen = 1'b1;
          running      = 1'b1;
          walk_pos     = 0;
          walk_back    = 1'b0;
        end
      end
      default: begin
      end
    endcase
    r.effect_running = running;
    r.led_mask       = led_on;
    return r;
  endfunction

  task automatic add_cmd(logic [2:0] act, logic [ldsp_pkg::MASK_W-1:0] m, logic [2:0] eff);
    cmd_t c;
    c.action = act;
    c.mask   = m;
    c.effect = eff;
    cmd_q.push_back(c);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("led_demux_scan_with_pattern_effects_core: mismatch");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin : drv
    cmd_t c;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.push_back(demux_result(s_axis_tuser, s_axis_tdata[5:0],
                                          s_axis_tdata[8:6]));
        sent_cnt <= sent_cnt + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cmd_q.size() > 0 && $urandom_range(99) >= sender_idle_pct(sent_cnt)) begin
          c = cmd_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {7'd0, c.effect, c.mask};
          s_axis_tuser  <= c.action;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin : mon
    ldsp_pkg::result_t e;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          $error("result word with nothing expected: tdata %h tuser %h",
                 m_axis_tdata, m_axis_tuser);
          err_cnt++;
        end else begin
          e = expected_q.pop_front();
          checked_cnt++;
          if (e.drive_valid) begin
            drive_cnt++;
          end
          if (m_axis_tuser[0] !== e.drive_valid) begin
            $error("drive_valid: expected %0d, got %0d", e.drive_valid, m_axis_tuser[0]);
            err_cnt++;
          end
          if (m_axis_tdata[4:0] !== e.port_value) begin
            $error("port_value: expected %0d, got %0d", e.port_value, m_axis_tdata[4:0]);
            err_cnt++;
          end
          if (m_axis_tdata[5] !== e.effect_running) begin
            $error("effect_running: expected %0d, got %0d", e.effect_running,
                   m_axis_tdata[5]);
            err_cnt++;
          end
          if (m_axis_tdata[11:6] !== e.led_mask) begin
            $error("led_mask: expected %0d, got %0d", e.led_mask, m_axis_tdata[11:6]);
            err_cnt++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && phase_of(sent_cnt) == 2) begin
        // long back-pressure so the output stage fills and tready drops
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct(sent_cnt));
      end
    end
  end

  initial begin
    int n;
    int burst;
    int r;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    sent_cnt      = 0;
    checked_cnt   = 0;
    drive_cnt     = 0;
    err_cnt       = 0;
    cycle_cnt     = 0;
    hold_left     = 0;
    hold_done     = 1'b0;
    led_on        = '0;
    scan_pos      = 0;
    walk_pos      = 0;
    walk_back     = 1'b0;
    table_chosen  = 1'b0;
    table_sel     = '0;
    running       = 1'b0;
    total_cmds    = 0;

    // directed part
    add_cmd(ldsp_pkg::ACT_SCAN, '0, '0);            // dark before anything
    add_cmd(ldsp_pkg::ACT_EFFECT, '0, '0);          // no table chosen yet
    add_cmd(ldsp_pkg::ACT_LOAD, 6'h3F, '0);
    for (int i = 0; i < ldsp_pkg::LED_COUNT; i++) begin
      add_cmd(ldsp_pkg::ACT_SCAN, '0, '0);          // every LED lit, then wrap
    end
    add_cmd(ldsp_pkg::ACT_LOAD, '0, 3'h7);
    add_cmd(ldsp_pkg::ACT_LOAD, 6'h2A, '0);
    add_cmd(ldsp_pkg::ACT_LOAD, 6'h15, '0);
    add_cmd(ldsp_pkg::ACT_START, 6'h3F, 3'h7);      // out of range, ignored
    add_cmd(ldsp_pkg::ACT_START, '0, 3'h4);
    add_cmd(ldsp_pkg::ACT_START, '0, 3'h0);
    add_cmd(ldsp_pkg::ACT_EFFECT, '0, '0);          // wide first entry shows dark
    add_cmd(ldsp_pkg::ACT_EFFECT, '0, '0);
    add_cmd(ldsp_pkg::ACT_OFF, 6'h3F, 3'h7);
    add_cmd(ldsp_pkg::ACT_EFFECT, '0, '0);          // walk goes on after all off
    add_cmd(ldsp_pkg::ACT_START, '0, 3'h1);
    for (int a = int'(ldsp_pkg::ACT_START) + 1; a < 8; a++) begin
      add_cmd(3'(a), 6'h3F, 3'h7);                  // undefined actions
    end
    add_cmd(ldsp_pkg::ACT_START, '0, 3'h3);
    add_cmd(ldsp_pkg::ACT_EFFECT, '0, '0);

    // random part: mostly effect walks with scans mixed in, plus noise
    n = 0;
    while (n < RANDOM_ITEMS) begin
      r = $urandom_range(99);
      if (r < 20) begin
        add_cmd(ldsp_pkg::ACT_START, 6'($urandom), 3'($urandom_range(3)));
        n++;
        burst = $urandom_range(10, 50);
        for (int i = 0; i < burst; i++) begin
          r = $urandom_range(99);
          if (r < 65) begin
            add_cmd(ldsp_pkg::ACT_EFFECT, 6'($urandom), 3'($urandom));
          end else if (r < 95) begin
            add_cmd(ldsp_pkg::ACT_SCAN, 6'($urandom), 3'($urandom));
          end else if (r < 98) begin
            add_cmd(ldsp_pkg::ACT_LOAD, 6'($urandom), 3'($urandom));
          end else begin
            add_cmd(ldsp_pkg::ACT_OFF, 6'($urandom), 3'($urandom));
          end
          n++;
        end
      end else begin
        r = $urandom_range(99);
        if (r < 35) begin
          add_cmd(ldsp_pkg::ACT_SCAN, 6'($urandom), 3'($urandom));
        end else if (r < 60) begin
          add_cmd(ldsp_pkg::ACT_EFFECT, 6'($urandom), 3'($urandom));
        end else if (r < 78) begin
          add_cmd(ldsp_pkg::ACT_LOAD, 6'($urandom), 3'($urandom));
        end else if (r < 85) begin
          add_cmd(ldsp_pkg::ACT_OFF, 6'($urandom), 3'($urandom));
        end else if (r < 95) begin
          add_cmd(ldsp_pkg::ACT_START, 6'($urandom), 3'($urandom_range(7)));
        end else begin
          add_cmd(ldsp_pkg::ACT_START + 3'($urandom_range(1, 3)), 6'($urandom),
                  3'($urandom));
        end
        n++;
      end
    end
    total_cmds = cmd_q.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (cmd_q.size() > 0 || s_axis_tvalid || expected_q.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_q.size());
      err_cnt++;
    end

    $display("%0d commands through directed cases, effect walks and noise,", total_cmds);
    $display("%0d result words checked, %0d of them demux drives", checked_cnt, drive_cnt);
    if (err_cnt == 0) begin
      $display("led_demux_scan_with_pattern_effects_core: match");
    end else begin
      $display("led_demux_scan_with_pattern_effects_core: mismatch");
    end
    $finish;
  end

endmodule
